FILE: src/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and constants of the laplacian sharpening filter
// Pixel, result and job structures, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package lsh_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int CHAN_W = 8;
   localparam int ROW_W = 12;
   localparam int COL_OUT_W = 11;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int MIN_DIM = 3;
   localparam int SHARP_GAIN = 5;
   localparam int CHAN_MAX = 255;

   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET = CSR_DATA_W'(640);
   localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

   // result slots of one request
   localparam int EMIT_INNER = 0;
   localparam int EMIT_EDGE = 1;
   localparam int EMIT_BOTTOM = 2;
   localparam int EMIT_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BORDER_MODE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_a;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_c;
   } pixel_type;

   typedef struct packed {
      logic [ROW_W-1:0]     out_row;
      logic [COL_OUT_W-1:0] out_col;
      logic [CHAN_W-1:0]    out_chan_a;
      logic [CHAN_W-1:0]    out_chan_b;
      logic [CHAN_W-1:0]    out_chan_c;
      logic                 last_of_run;
      logic                 frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [EMIT_W-1:0]    emit;
      logic                 done;
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
   } job_type;

endpackage

FILE: src/lsh_if.sv
// ----------------------------------------------------------------------------
// lsh_if: request and result channels of the sharpening filter
// Valid/ready channels carrying one pixel or one result pixel.
// ----------------------------------------------------------------------------
interface lsh_req_if;
   import lsh_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lsh_rsp_if;
   import lsh_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/lsh_lane.sv
// ----------------------------------------------------------------------------
// lsh_lane: one colour channel of the five-point sharpening kernel
// Computes 5*centre minus the four neighbours, clamps to 0..255 and
// registers either that or the border value.
// ----------------------------------------------------------------------------
module lsh_lane (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        interior,
   input  logic                        border_copy,
   input  logic [lsh_pkg::CHAN_W-1:0]  centre,
   input  logic [lsh_pkg::CHAN_W-1:0]  up_px,
   input  logic [lsh_pkg::CHAN_W-1:0]  down_px,
   input  logic [lsh_pkg::CHAN_W-1:0]  west_px,
   input  logic [lsh_pkg::CHAN_W-1:0]  east_px,
   output logic [lsh_pkg::CHAN_W-1:0]  result_ff
);
   import lsh_pkg::*;

   localparam int SUM_W = CHAN_W + 4;

   logic signed [SUM_W-1:0] gain_sum;
   logic signed [SUM_W-1:0] ring_sum;
   logic signed [SUM_W-1:0] diff;
   logic [CHAN_W-1:0]       sharp;
   logic [CHAN_W-1:0]       result_in;

   always_comb begin
      gain_sum = signed'(SUM_W'(centre) * SUM_W'(SHARP_GAIN));
      ring_sum = signed'(SUM_W'(up_px) + SUM_W'(down_px) + SUM_W'(west_px)
                         + SUM_W'(east_px));
      diff = gain_sum - ring_sum;
      priority if (diff < 0) begin
         sharp = '0;
      end else if (diff > signed'(SUM_W'(CHAN_MAX))) begin
         sharp = CHAN_W'(CHAN_MAX);
      end else begin
         sharp = diff[CHAN_W-1:0];
      end
      if (interior) begin
         result_in = sharp;
      end else if (border_copy) begin
         result_in = centre;
      end else begin
         result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

FILE: src/lsh_merge.sv
// ----------------------------------------------------------------------------
// lsh_merge: result merger and output register
// Joins the lane channels into the inner result, holds the edge and bottom-row
// border results of one request; hands them out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module lsh_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  lsh_pkg::job_type    job,
   input  lsh_pkg::pixel_type  inner_px,
   input  lsh_pkg::pixel_type  rim_px,
   input  lsh_pkg::pixel_type  bottom_px,
   output logic                free,
   lsh_rsp_if.source           rsp_chan
);
   import lsh_pkg::*;

   logic [EMIT_W-1:0] emit_ff;
   logic [EMIT_W-1:0] emit_in;
   logic [EMIT_W-1:0] pick;
   logic [EMIT_W-1:0] rest;
   job_type           job_ff;
   pixel_type         rim_ff;
   pixel_type         bottom_ff;
   pixel_type         sel_px;
   logic              o_valid_ff;
   logic              o_valid_in;
   logic              o_load;
   rsp_payload_type   o_data_ff;
   rsp_payload_type   o_data_in;

   always_comb begin
      pick = emit_ff & (~emit_ff + EMIT_W'(1));
      rest = emit_ff & ~pick;
      o_load = (emit_ff != '0) && (!o_valid_ff || rsp_chan.ready);
      free = (emit_ff == '0) || (o_load && (rest == '0));

      emit_in = emit_ff;
      if (take) begin
         emit_in = job.emit;
      end else if (o_load) begin
         emit_in = rest;
      end

      o_valid_in = o_valid_ff;
      if (o_load) begin
         o_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         o_valid_in = 1'b0;
      end

      priority if (pick[EMIT_INNER]) begin
         sel_px = inner_px;
      end else if (pick[EMIT_EDGE]) begin
         sel_px = rim_ff;
      end else begin
         sel_px = bottom_ff;
      end

      o_data_in.out_row = pick[EMIT_BOTTOM] ? job_ff.row : job_ff.row - ROW_W'(1);
      o_data_in.out_col = pick[EMIT_INNER] ? job_ff.col - COL_OUT_W'(1) : job_ff.col;
      o_data_in.out_chan_a = sel_px.chan_a;
      o_data_in.out_chan_b = sel_px.chan_b;
      o_data_in.out_chan_c = sel_px.chan_c;
      o_data_in.last_of_run = (rest == '0);
      o_data_in.frame_done = pick[EMIT_BOTTOM] && job_ff.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         emit_ff <= emit_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job;
         rim_ff <= rim_px;
         bottom_ff <= bottom_px;
      end
      if (o_load) begin
         o_data_ff <= o_data_in;
      end
   end

   assign rsp_chan.valid = o_valid_ff;
   assign rsp_chan.payload = o_data_ff;

`ifndef ASSERT_OFF
   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      take |-> free)
      else $error("new request taken while results still pending");

   a_emit_shrinks: assert property (@(posedge clock) disable iff (reset)
      !reset && !take |=> (emit_ff & ~$past(emit_ff)) == '0)
      else $error("pending result slots grew without a new request");

   a_single_pick: assert property (@(posedge clock) disable iff (reset)
      o_load |-> $onehot(pick))
      else $error("output load without exactly one selected slot");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && o_data_ff.frame_done |-> o_data_ff.last_of_run)
      else $error("frame end not on the last result of its request");
`endif

endmodule

FILE: src/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3: five-point laplacian sharpening of an rgb stream
// Pixels arrive in raster order on req_chan, one per request; result pixels
// with their row and column leave on rsp_chan.
// ----------------------------------------------------------------------------
// csr_write_enable, csr_index and csr_write_data set image width, image height
// and border mode; write them only while the stream is idle.
// a result pixel is completed by the request one row and one pixel later
// (last-column pixels one row later, bottom-row pixels by their own request);
// a request's first result passes the input stage, lane and merge registers
// and output register. one request per cycle is taken while the output keeps
// up; the output register gives one result per cycle, so after the last pixel
// of a row past the first (two results) or a bottom-row pixel past the first
// column (two, three at the row end) the next request waits for all of them.
// two single-port-read row memories hold the previous two rows; they are not
// cleared at reset, and reset returns counters, window and output to idle.
// when rsp_chan stalls, the pending results hold and req_chan.ready drops
// once the output register, the merge stage and the input stage are all full.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 #(
   parameter int MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   lsh_req_if.sink                           req_chan,
   lsh_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [lsh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lsh_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import lsh_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = (CW + 1 > CSR_DATA_W) ? CW + 1 : CSR_DATA_W;

   // configuration
   logic [CSR_DATA_W-1:0] width_ff;
   logic [ROW_W-1:0]      height_ff;
   logic                  border_ff;
   logic [XW-1:0]         width_x;
   logic [CW-1:0]         w_last;
   logic [ROW_W-1:0]      h_last;

   // position counters
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   logic [ROW_W-1:0] cur_row;
   logic [CW-1:0]    cur_col;
   logic             at_end;
   logic             at_bottom;

   // stage a
   logic      req_go;
   logic      a_go;
   logic      a_valid_ff;
   pixel_type a_pix_ff;
   logic [CW-1:0] a_addr_ff;
   job_type   a_job_ff;
   job_type   job_in;
   logic      a_interior_ff;
   logic      interior_in;

   // row memories and window
   pixel_type older_mem [MAX_WIDTH];
   pixel_type newer_mem [MAX_WIDTH];
   pixel_type top_rd_ff;
   pixel_type mid_rd_ff;
   pixel_type win_top_ff;
   pixel_type win_mid_ff;
   pixel_type win_bot_ff;
   pixel_type win_west_ff;

   pixel_type inner_px;
   pixel_type rim_px;
   pixel_type bottom_px;
   logic      merge_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         border_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_write_data;
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= ROW_W'(csr_write_data);
            end
            CSR_BORDER_MODE: begin
               border_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      width_x = XW'(width_ff);
      if (width_x < XW'(MIN_DIM)) begin
         width_x = XW'(MIN_DIM);
      end else if (width_x > XW'(MAX_WIDTH)) begin
         width_x = XW'(MAX_WIDTH);
      end
      w_last = CW'(width_x - XW'(1));
      h_last = (height_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1)
                                             : height_ff - ROW_W'(1);
   end

   assign a_go = a_valid_ff && merge_free;
   assign req_chan.ready = !a_valid_ff || a_go;
   assign req_go = req_chan.valid && req_chan.ready;

   always_comb begin
      cur_row = (row_ff > h_last) ? h_last : row_ff;
      cur_col = (col_ff > w_last) ? w_last : col_ff;
      at_end = (cur_col == w_last);
      at_bottom = (cur_row == h_last);

      job_in.emit[EMIT_INNER] = (cur_row != '0) && (cur_col != '0);
      job_in.emit[EMIT_EDGE] = (cur_row != '0) && at_end;
      job_in.emit[EMIT_BOTTOM] = at_bottom;
      job_in.done = at_end;
      job_in.row = cur_row;
      job_in.col = COL_OUT_W'(cur_col);
      interior_in = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));

      if (at_end) begin
         col_in = '0;
         row_in = at_bottom ? '0 : cur_row + ROW_W'(1);
      end else begin
         col_in = cur_col + CW'(1);
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (req_go) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (req_go) begin
            a_valid_ff <= 1'b1;
         end else if (a_go) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         a_pix_ff <= req_chan.payload;
         a_addr_ff <= cur_col;
         a_job_ff <= job_in;
         a_interior_ff <= interior_in;
      end
   end

   // row memories: read on request, written back when the request moves on
   always_ff @(posedge clock) begin
      if (req_go) begin
         top_rd_ff <= older_mem[cur_col];
         mid_rd_ff <= newer_mem[cur_col];
      end
      if (a_go) begin
         older_mem[a_addr_ff] <= mid_rd_ff;
         newer_mem[a_addr_ff] <= a_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_top_ff <= '0;
         win_mid_ff <= '0;
         win_bot_ff <= '0;
         win_west_ff <= '0;
      end else if (a_go) begin
         win_west_ff <= win_mid_ff;
         win_top_ff <= top_rd_ff;
         win_mid_ff <= mid_rd_ff;
         win_bot_ff <= a_pix_ff;
      end
   end

   lsh_lane lane_a (
      .clock       (clock),
      .load        (a_go),
      .interior    (a_interior_ff),
      .border_copy (border_ff),
      .centre      (win_mid_ff.chan_a),
      .up_px       (win_top_ff.chan_a),
      .down_px     (win_bot_ff.chan_a),
      .west_px     (win_west_ff.chan_a),
      .east_px     (mid_rd_ff.chan_a),
      .result_ff   (inner_px.chan_a)
   );

   lsh_lane lane_b (
      .clock       (clock),
      .load        (a_go),
      .interior    (a_interior_ff),
      .border_copy (border_ff),
      .centre      (win_mid_ff.chan_b),
      .up_px       (win_top_ff.chan_b),
      .down_px     (win_bot_ff.chan_b),
      .west_px     (win_west_ff.chan_b),
      .east_px     (mid_rd_ff.chan_b),
      .result_ff   (inner_px.chan_b)
   );

   lsh_lane lane_c (
      .clock       (clock),
      .load        (a_go),
      .interior    (a_interior_ff),
      .border_copy (border_ff),
      .centre      (win_mid_ff.chan_c),
      .up_px       (win_top_ff.chan_c),
      .down_px     (win_bot_ff.chan_c),
      .west_px     (win_west_ff.chan_c),
      .east_px     (mid_rd_ff.chan_c),
      .result_ff   (inner_px.chan_c)
   );

   assign rim_px = border_ff ? mid_rd_ff : '0;
   assign bottom_px = border_ff ? a_pix_ff : '0;

   lsh_merge merge (
      .clock     (clock),
      .reset     (reset),
      .take      (a_go),
      .job       (a_job_ff),
      .inner_px  (inner_px),
      .rim_px    (rim_px),
      .bottom_px (bottom_px),
      .free      (merge_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: tb/sv/tb_laplacian_sharpen_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laplacian_sharpen_3x3: self-checking bench for the sharpening filter
// Streams small frames of rgb pixels through the filter with random idle
// bursts on both channels. A built-in model of the row stores and window
// predicts every result pixel, and the results are compared field by field
// in order of arrival. A short table first covers reset sizes, clamped sizes
// and counters, and channel saturation.
// ----------------------------------------------------------------------------
module tb_laplacian_sharpen_3x3;
   import lsh_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS = 20;
   localparam pixel_type ZERO_PX = '0;

   typedef struct packed {
      logic typed;
      pixel_type px;
   } pinned_type;

   typedef struct packed {
      logic                  cfg_before;
      logic [CSR_DATA_W-1:0] cfg_w;
      logic [CSR_DATA_W-1:0] cfg_h;
      logic [CSR_DATA_W-1:0] cfg_mode;
      pixel_type             pix;
      logic                  typed;
      pixel_type             typed_px;
   } directed_row_type;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   lsh_req_if req_chan ();
   lsh_rsp_if rsp_chan ();

   // sharpener state
   logic [CSR_DATA_W-1:0] cfg_width = WIDTH_RESET;
   logic [ROW_W-1:0]      cfg_height = HEIGHT_RESET;
   logic                  cfg_border = 1'b0;
   pixel_type             older_row [MAX_WIDTH_DEFAULT];
   pixel_type             newer_row [MAX_WIDTH_DEFAULT];
   pixel_type             win [6];
   int unsigned           row_pos = 0;
   int unsigned           col_pos = 0;

   rsp_payload_type due_pixels [$];
   pinned_type      pinned_q [$];

   bit          idling_on = 1'b1;
   int unsigned sent_count = 0;
   int unsigned results_seen = 0;
   int unsigned frames_done = 0;
   int unsigned fail_count = 0;
   rsp_payload_type got_px;
   rsp_payload_type want_px;

   // row 4 shrinks width and height while the column counter is past the end;
   // row 20 shrinks height while the row counter is past the end
   directed_row_type directed_rows [23] = '{
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd255, 8'd255, 8'd255}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd0, 8'd255, 8'd10}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd0, 8'd0, 8'd0}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd255, 8'd255, 8'd255}, 1'b1, ZERO_PX},
      '{1'b1, 12'd1, 12'd2, 12'hFFE, '{8'd128, 8'd64, 8'd32}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd0, 8'd255, 8'd10}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd255, 8'd0, 8'd50}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd0, 8'd255, 8'd10}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd255, 8'd0, 8'd255}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd0, 8'd255, 8'd10}, 1'b1, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd1, 8'd2, 8'd4}, 1'b1,
        '{8'd255, 8'd0, 8'd210}},
      '{1'b1, 12'd3, 12'd4, 12'hF01, '{8'd17, 8'd34, 8'd51}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd200, 8'd1, 8'd128}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd255, 8'd0, 8'd127}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd90, 8'd160, 8'd3}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd240, 8'd15, 8'd99}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd8, 8'd250, 8'd60}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd77, 8'd77, 8'd77}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd100, 8'd200, 8'd0}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd33, 8'd66, 8'd255}, 1'b0, ZERO_PX},
      '{1'b1, 12'd3, 12'd3, 12'd1, '{8'd64, 8'd128, 8'd192}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd5, 8'd250, 8'd170}, 1'b0, ZERO_PX},
      '{1'b0, 12'd0, 12'd0, 12'd0, '{8'd255, 8'd255, 8'd0}, 1'b0, ZERO_PX}
   };

   laplacian_sharpen_3x3 u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned eff_width(input logic [CSR_DATA_W-1:0] w);
      if (w < MIN_DIM) return MIN_DIM;
      if (w > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return int'(w);
   endfunction

   function automatic int unsigned eff_height(input logic [ROW_W-1:0] h);
      return (h < MIN_DIM) ? MIN_DIM : int'(h);
   endfunction

   function automatic logic [CHAN_W-1:0] sharpen_chan(
      input logic [CHAN_W-1:0] centre, up, down, left, right);
      int s;
      s = SHARP_GAIN * int'(centre) - int'(up) - int'(down) - int'(left) - int'(right);
      if (s < 0) s = 0;
      if (s > CHAN_MAX) s = CHAN_MAX;
      return CHAN_W'(s);
   endfunction

   function automatic pixel_type sharpen_px(input pixel_type m, u, d, l, r);
      pixel_type v;
      v.chan_a = sharpen_chan(m.chan_a, u.chan_a, d.chan_a, l.chan_a, r.chan_a);
      v.chan_b = sharpen_chan(m.chan_b, u.chan_b, d.chan_b, l.chan_b, r.chan_b);
      v.chan_c = sharpen_chan(m.chan_c, u.chan_c, d.chan_c, l.chan_c, r.chan_c);
      return v;
   endfunction

   function automatic rsp_payload_type make_result(input int unsigned r, c,
                                                   input pixel_type v, input bit done);
      rsp_payload_type o;
      o.out_row = ROW_W'(r);
      o.out_col = COL_OUT_W'(c);
      o.out_chan_a = v.chan_a;
      o.out_chan_b = v.chan_b;
      o.out_chan_c = v.chan_c;
      o.last_of_run = 1'b0;
      o.frame_done = done;
      return o;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH: cfg_width = data;
         CSR_IMAGE_HEIGHT: cfg_height = ROW_W'(data);
         CSR_BORDER_MODE: cfg_border = data[0];
         default: ;
      endcase
   endfunction

   // works out the results caused by one request and moves the window on
   function automatic void advance_sharpener(input pixel_type px, input pinned_type pin);
      int unsigned w, h, r, c, n;
      pixel_type top, mid, v;
      rsp_payload_type outs [3];
      bit interior;
      w = eff_width(cfg_width);
      h = eff_height(cfg_height);
      r = (row_pos > h - 1) ? h - 1 : row_pos;
      c = (col_pos > w - 1) ? w - 1 : col_pos;
      top = older_row[c];
      mid = newer_row[c];
      n = 0;
      if (r >= 1 && c >= 1) begin
         interior = (r - 1 >= 1) && (r - 1 <= h - 2) && (c - 1 >= 1) && (c - 1 <= w - 2);
         if (interior) v = sharpen_px(win[1], win[0], win[2], win[4], mid);
         else v = cfg_border ? win[1] : ZERO_PX;
         outs[n] = make_result(r - 1, c - 1, v, 1'b0);
         n++;
      end
      if (r >= 1 && c == w - 1) begin
         outs[n] = make_result(r - 1, c, cfg_border ? mid : ZERO_PX, 1'b0);
         n++;
      end
      if (r == h - 1) begin
         outs[n] = make_result(r, c, cfg_border ? px : ZERO_PX, c == w - 1);
         n++;
      end
      for (int unsigned k = 0; k < n; k++) begin
         if (pin.typed) begin
            v = (k == 0) ? pin.px : ZERO_PX;
            outs[k].out_chan_a = v.chan_a;
            outs[k].out_chan_b = v.chan_b;
            outs[k].out_chan_c = v.chan_c;
         end
         outs[k].last_of_run = (k == n - 1);
         due_pixels.push_back(outs[k]);
      end
      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = top;
      win[1] = mid;
      win[2] = px;
      older_row[c] = mid;
      newer_row[c] = px;
      if (c >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [ROW_W-1:0] got,
                              input logic [ROW_W-1:0] want);
      if (got !== want)
         report($sformatf("pixel (%0d,%0d) %s got %0d want %0d",
                          want_px.out_row, want_px.out_col, name, got, want));
   endtask

   // request and register observer feeding the sharpener
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) apply_csr(csr_index, csr_write_data);
         if (req_chan.valid && req_chan.ready) begin
            if (pinned_q.size() == 0) report("request taken that was never offered");
            else advance_sharpener(req_chan.payload, pinned_q.pop_front());
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_px = rsp_chan.payload;
         results_seen++;
         if (got_px.frame_done === 1'b1) frames_done++;
         if (due_pixels.size() == 0) begin
            report($sformatf("result pixel (%0d,%0d) with nothing due",
                             got_px.out_row, got_px.out_col));
         end else begin
            want_px = due_pixels.pop_front();
            check_field("out_row", got_px.out_row, want_px.out_row);
            check_field("out_col", ROW_W'(got_px.out_col), ROW_W'(want_px.out_col));
            check_field("out_chan_a", ROW_W'(got_px.out_chan_a),
                        ROW_W'(want_px.out_chan_a));
            check_field("out_chan_b", ROW_W'(got_px.out_chan_b),
                        ROW_W'(want_px.out_chan_b));
            check_field("out_chan_c", ROW_W'(got_px.out_chan_c),
                        ROW_W'(want_px.out_chan_c));
            check_field("last_of_run", ROW_W'(got_px.last_of_run),
                        ROW_W'(want_px.last_of_run));
            check_field("frame_done", ROW_W'(got_px.frame_done),
                        ROW_W'(want_px.frame_done));
         end
      end
   end

   // result back-pressure in short bursts
   initial begin : rsp_stall
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #4ms;
      $display("status: fail");
      $finish;
   end

   task automatic send_pixel(input pixel_type px, input logic typed, input pixel_type typed_px);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      pinned_q.push_back({typed, typed_px});
      req_chan.valid <= 1'b1;
      req_chan.payload <= px;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   // hold requests until every due result is out and the pipe has settled
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] w_data, h_data, mode_data);
      drain_results();
      write_csr(CSR_IMAGE_WIDTH, w_data);
      write_csr(CSR_IMAGE_HEIGHT, h_data);
      write_csr(CSR_BORDER_MODE, mode_data);
      write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CHAN_W-1:0] random_chan();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CHAN_W'(CHAN_MAX);
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.chan_a = random_chan();
      px.chan_b = random_chan();
      px.chan_c = random_chan();
      return px;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_dim(input int unsigned hi);
      if ($urandom_range(0, 5) == 0) return CSR_DATA_W'($urandom_range(0, MIN_DIM - 1));
      return CSR_DATA_W'($urandom_range(MIN_DIM, hi));
   endfunction

   task automatic run_frame(input logic [CSR_DATA_W-1:0] w_data, h_data, mode_data,
                            input bit pause_mid);
      int unsigned n;
      configure(w_data, h_data, mode_data);
      n = eff_width(w_data) * eff_height(h_data);
      for (int unsigned k = 0; k < n; k++) begin
         if (pause_mid && k == n / 2) drain_results();
         send_pixel(random_pixel(), 1'b0, ZERO_PX);
      end
   endtask

   initial begin
      int unsigned mark;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg_before)
            configure(directed_rows[i].cfg_w, directed_rows[i].cfg_h,
                      directed_rows[i].cfg_mode);
         send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].typed_px);
      end

      for (int f = 0; sent_count < 70; f++)
         run_frame(random_dim(9), random_dim(6), CSR_DATA_W'($urandom), f == 0);

      // closing stretch with both channels flat out
      idling_on = 1'b0;
      mark = sent_count;
      while (sent_count < mark + 45)
         run_frame(random_dim(9), random_dim(6), CSR_DATA_W'($urandom), 1'b0);

      drain_results();
      $display("covered %0d pixels in, %0d result pixels checked, %0d frames completed",
               sent_count, results_seen, frames_done);
      $display("frame sizes from 3x3 up to 9x6, clamped sizes and counters, both modes");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
